FILE: sv/look_at_view_matrix_top_assert.svh
// Assertion macros for the look-at view matrix block.
// Used by the port checker; depends on clk and rst being in scope.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Checked property, off while reset is high.
`define LAVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds across reset.
`define LAVM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lavm_pkg.sv
// Shared constants and types of the look-at view matrix block.
// No dependencies.
`default_nettype none

package lavm_pkg;
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_WIDTH    = 32;
  localparam int ENTRY_COUNT = 16;
  localparam int INDEX_WIDTH = 4;

  typedef logic [INDEX_WIDTH-1:0] entry_index_t;

  localparam entry_index_t LAST_INDEX = entry_index_t'(ENTRY_COUNT - 1);
endpackage

`default_nettype wire

FILE: sv/lavm_norm.sv
// Vector normalizer of the look-at view matrix block: range shift, squares,
// iterative square root and iterative divide, one item per stage.
// Depends on lavm_pkg.
`default_nettype none

module lavm_norm #(
  parameter int IW        = 33,
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS,
  parameter int SW        = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [IW-1:0]   in_vec [3],
  input  logic [SW-1:0]          in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [FRAC_BITS+1:0] out_vec [3],
  output logic                   out_ok,
  output logic [SW-1:0]          out_side
);

  localparam int MW  = (IW > 31) ? IW : 31;
  localparam int FW  = FRAC_BITS + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 31;
  localparam int QCW = $clog2(QW + 1);
  localparam logic [3:0] SQRT_LAST = 4'(15);

  // Range shift stage.
  logic          a_valid, a_run, a_fire, a_hold;
  logic [MW-1:0] a_m [3];
  logic [MW-1:0] a_m_next [3];
  logic [MW-1:0] a_mx;
  logic [2:0]    a_neg;
  logic [SW-1:0] a_side;

  // Squares stage.
  logic          b_valid, b_ready, b_fire, b_zero;
  logic [29:0]   b_m [3];
  logic [59:0]   b_sq [3];
  logic [2:0]    b_neg;
  logic [SW-1:0] b_side;

  // Square root stage.
  logic          c_valid, c_run, c_ready, c_fire, c_zero;
  logic [3:0]    c_cnt;
  logic [63:0]   c_x, c_r, c_bit, c_x_next, c_r_next, c_bit_next;
  logic [29:0]   c_m [3];
  logic [2:0]    c_neg;
  logic [SW-1:0] c_side;

  // Divide stage.
  logic           d_valid, d_run, d_ready, d_fire, d_zero;
  logic [QCW-1:0] d_left, d_left_next;
  logic [31:0]    d_len;
  logic [NW-1:0]  d_rem [3];
  logic [NW-1:0]  d_rem_next [3];
  logic [NW-1:0]  d_dv;
  logic [QW-1:0]  d_q [3];
  logic [QW-1:0]  d_q_next [3];
  logic [2:0]     d_neg;
  logic [SW-1:0]  d_side;

  assign a_fire   = a_valid && !a_run && b_ready;
  assign in_ready = !a_valid || a_fire;
  assign b_fire   = b_valid && c_ready;
  assign b_ready  = !b_valid || b_fire;
  assign c_fire   = c_valid && !c_run && d_ready;
  assign c_ready  = !c_valid || c_fire;
  assign d_fire   = d_valid && !d_run && out_ready;
  assign d_ready  = !d_valid || d_fire;

  always_comb begin
    a_mx = a_m[0];
    if (a_m[1] > a_mx) a_mx = a_m[1];
    if (a_m[2] > a_mx) a_mx = a_m[2];
    a_hold = 1'b0;
    for (int i = 0; i < 3; i++) a_m_next[i] = a_m[i];
    if (a_mx == '0) begin
      a_hold = 1'b0;
    end else if ((a_mx >> 38) != '0) begin
      for (int i = 0; i < 3; i++) a_m_next[i] = a_m[i] >> 8;
      a_hold = 1'b1;
    end else if ((a_mx >> 30) != '0) begin
      for (int i = 0; i < 3; i++) a_m_next[i] = a_m[i] >> 1;
      a_hold = 1'b1;
    end else if ((a_mx >> 22) == '0) begin
      for (int i = 0; i < 3; i++) a_m_next[i] = a_m[i] << 8;
      a_hold = 1'b1;
    end else if ((a_mx >> 29) == '0) begin
      for (int i = 0; i < 3; i++) a_m_next[i] = a_m[i] << 1;
      a_hold = 1'b1;
    end
  end

  always_comb begin
    c_x_next   = c_x;
    c_r_next   = c_r;
    c_bit_next = c_bit;
    for (int k = 0; k < 2; k++) begin
      if (c_x_next >= c_r_next + c_bit_next) begin
        c_x_next = c_x_next - (c_r_next + c_bit_next);
        c_r_next = (c_r_next >> 1) + c_bit_next;
      end else begin
        c_r_next = c_r_next >> 1;
      end
      c_bit_next = c_bit_next >> 2;
    end
  end

  always_comb begin
    d_left_next = d_left;
    d_dv        = '0;
    for (int i = 0; i < 3; i++) begin
      d_rem_next[i] = d_rem[i];
      d_q_next[i]   = d_q[i];
    end
    for (int k = 0; k < 2; k++) begin
      if (d_left_next != '0) begin
        d_dv = NW'(d_len) << (d_left_next - QCW'(1));
        for (int i = 0; i < 3; i++) begin
          if (d_rem_next[i] >= d_dv) begin
            d_rem_next[i] = d_rem_next[i] - d_dv;
            d_q_next[i]   = {d_q_next[i][QW-2:0], 1'b1};
          end else begin
            d_q_next[i]   = {d_q_next[i][QW-2:0], 1'b0};
          end
        end
        d_left_next = d_left_next - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_run   <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      c_run   <= 1'b0;
      c_cnt   <= '0;
      d_valid <= 1'b0;
      d_run   <= 1'b0;
      d_left  <= '0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
        a_run   <= in_valid;
      end else if (a_run) begin
        a_run <= a_hold;
      end
      if (b_ready) b_valid <= a_valid && !a_run;
      if (c_ready) begin
        c_valid <= b_valid;
        c_run   <= b_valid;
        c_cnt   <= '0;
      end else if (c_run) begin
        c_cnt <= c_cnt + 4'(1);
        if (c_cnt == SQRT_LAST) c_run <= 1'b0;
      end
      if (d_ready) begin
        d_valid <= c_valid && !c_run;
        d_run   <= c_valid && !c_run && !c_zero;
        d_left  <= c_zero ? '0 : QCW'(QW);
      end else if (d_run) begin
        d_left <= d_left_next;
        d_run  <= (d_left_next != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      for (int i = 0; i < 3; i++) begin
        a_neg[i] <= in_vec[i][IW-1];
        a_m[i]   <= MW'($unsigned(in_vec[i][IW-1] ? -in_vec[i] : in_vec[i]));
      end
      a_side <= in_side;
    end else if (a_run) begin
      for (int i = 0; i < 3; i++) a_m[i] <= a_m_next[i];
    end

    if (b_ready) begin
      for (int i = 0; i < 3; i++) begin
        b_m[i]  <= a_m[i][29:0];
        b_sq[i] <= a_m[i][29:0] * a_m[i][29:0];
      end
      b_neg  <= a_neg;
      b_zero <= (a_mx == '0);
      b_side <= a_side;
    end

    if (c_ready) begin
      c_x    <= 64'(b_sq[0]) + 64'(b_sq[1]) + 64'(b_sq[2]);
      c_r    <= '0;
      c_bit  <= 64'(1) << 62;
      c_m    <= b_m;
      c_neg  <= b_neg;
      c_zero <= b_zero;
      c_side <= b_side;
    end else if (c_run) begin
      c_x   <= c_x_next;
      c_r   <= c_r_next;
      c_bit <= c_bit_next;
    end

    if (d_ready) begin
      d_len <= c_r[31:0];
      for (int i = 0; i < 3; i++) begin
        d_rem[i] <= (NW'(c_m[i]) << FRAC_BITS) + NW'(c_r[31:1]);
        d_q[i]   <= '0;
      end
      d_neg  <= c_neg;
      d_zero <= c_zero;
      d_side <= c_side;
    end else if (d_run) begin
      d_rem <= d_rem_next;
      d_q   <= d_q_next;
    end
  end

  assign out_valid = d_valid && !d_run;
  assign out_ok    = !d_zero;
  assign out_side  = d_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_vec[i] = d_neg[i] ? -FW'(d_q[i]) : FW'(d_q[i]);
    end
  end

endmodule

`default_nettype wire

FILE: sv/look_at_view_matrix_top.sv
// Look-at view matrix builder: two normalizers, cross and dot product stages
// and a sixteen-entry output serializer. Depends on lavm_pkg and lavm_norm.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | eye_*, target_*, upward_* (signed fixed pt)
//   result   | out_valid / out_ready| entry_index, entry_value, degenerate, last_entry
//
// Each item yields sixteen result items, one per cycle while out_ready is high, in
// column-major order. Input throughput is set by the square root stage of each
// normalizer, two root bits per cycle for a 64-bit radicand; each stage holds one
// item, and the divide is skipped when a vector has zero length. Reset is
// synchronous and empties every stage; a stalled result holds the serializer,
// and the stages behind it fill before the input stalls.
`default_nettype none

module look_at_view_matrix_top #(
  parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS,
  parameter int VALUE_WIDTH = lavm_pkg::VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] eye_x,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] eye_y,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] eye_z,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] target_x,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] target_y,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] target_z,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] upward_x,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] upward_y,
  input  logic signed [lavm_pkg::IN_WIDTH-1:0] upward_z,
  output logic out_valid,
  input  logic out_ready,
  output lavm_pkg::entry_index_t entry_index,
  output logic signed [VALUE_WIDTH-1:0] entry_value,
  output logic degenerate,
  output logic last_entry
);

  localparam int IN_W = lavm_pkg::IN_WIDTH;
  localparam int FW   = FRAC_BITS + 2;
  localparam int DW   = IN_W + 1;
  localparam int PW   = FW + IN_W;
  localparam int CW   = PW + 1;
  localparam int UW   = FRAC_BITS + 3;
  localparam int UEW  = UW + IN_W;
  localparam int WW   = 2 * FRAC_BITS + 40;
  localparam int SW1  = 6 * IN_W;
  localparam int SW2  = 3 * FW + 3 * IN_W + 1;

  localparam logic signed [WW-1:0] SAT_HI = (WW'(1) <<< (VALUE_WIDTH - 1)) - WW'(1);
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);
  localparam logic signed [WW-1:0] ONE    = WW'(1) <<< FRAC_BITS;

  function automatic logic signed [WW-1:0] rescale(input logic signed [WW-1:0] v);
    logic [WW-1:0] m;
    m = v[WW-1] ? $unsigned(-v) : $unsigned(v);
    m = (m + (WW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[WW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] sat(input logic signed [WW-1:0] v);
    if (v > SAT_HI) return SAT_HI[VALUE_WIDTH-1:0];
    else if (v < SAT_LO) return SAT_LO[VALUE_WIDTH-1:0];
    else return v[VALUE_WIDTH-1:0];
  endfunction

  // Forward normalizer.
  logic signed [DW-1:0] n1_in [3];
  logic [SW1-1:0]       n1_side_in, n1_side;
  logic                 n1_valid, n1_ok;
  logic signed [FW-1:0] n1_f [3];
  logic signed [IN_W-1:0] n1_eye [3];
  logic signed [IN_W-1:0] n1_up [3];

  // Side normalizer.
  logic signed [CW-1:0] n2_in [3];
  logic [SW2-1:0]       n2_side_in, n2_side;
  logic                 n2_ready, n2_valid, n2_ok;
  logic signed [FW-1:0] n2_s [3];
  logic signed [FW-1:0] n2_f [3];
  logic signed [IN_W-1:0] n2_eye [3];

  // Cross product stage.
  logic                   x_valid, x_ready, x_okf;
  logic signed [PW-1:0]   x_p [6];
  logic signed [FW-1:0]   x_f [3];
  logic signed [IN_W-1:0] x_eye [3];

  // Product stage.
  logic                    p_valid, p_ready, p_deg;
  logic signed [2*FW-1:0]  p_uf [6];
  logic signed [PW-1:0]    p_se [3];
  logic signed [PW-1:0]    p_fe [3];
  logic signed [FW-1:0]    p_s [3];
  logic signed [FW-1:0]    p_f [3];
  logic signed [IN_W-1:0]  p_eye [3];

  // Sum stage.
  logic                   q_valid, q_ready, q_deg;
  logic signed [WW-1:0]   q_ud [3];
  logic signed [WW-1:0]   q_ts, q_tf;
  logic signed [FW-1:0]   q_s [3];
  logic signed [FW-1:0]   q_f [3];
  logic signed [IN_W-1:0] q_eye [3];

  // Rescale stage.
  logic                   r_valid, r_ready, r_deg;
  logic signed [UW-1:0]   r_u [3];
  logic signed [WW-1:0]   r_m12, r_m14;
  logic signed [FW-1:0]   r_s [3];
  logic signed [FW-1:0]   r_f [3];
  logic signed [IN_W-1:0] r_eye [3];

  // Up dot eye product stage.
  logic                  t_valid, t_ready, t_deg;
  logic signed [UEW-1:0] t_ue [3];
  logic signed [UW-1:0]  t_u [3];
  logic signed [WW-1:0]  t_m12, t_m14;
  logic signed [FW-1:0]  t_s [3];
  logic signed [FW-1:0]  t_f [3];

  // Up dot eye sum stage.
  logic                 w_valid, w_ready, w_deg;
  logic signed [WW-1:0] w_tu, w_m12, w_m14;
  logic signed [UW-1:0] w_u [3];
  logic signed [FW-1:0] w_s [3];
  logic signed [FW-1:0] w_f [3];

  // Matrix register and serializer.
  logic                   m_valid, m_ready, m_deg;
  logic [VALUE_WIDTH-1:0] mat [lavm_pkg::ENTRY_COUNT];
  lavm_pkg::entry_index_t cnt;

  assign n1_in[0]  = DW'(target_x) - DW'(eye_x);
  assign n1_in[1]  = DW'(target_y) - DW'(eye_y);
  assign n1_in[2]  = DW'(target_z) - DW'(eye_z);
  assign n1_side_in = {upward_z, upward_y, upward_x, eye_z, eye_y, eye_x};

  lavm_norm #(
    .IW(DW), .FRAC_BITS(FRAC_BITS), .SW(SW1)
  ) u_norm_f (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_vec(n1_in), .in_side(n1_side_in),
    .out_valid(n1_valid), .out_ready(x_ready), .out_vec(n1_f), .out_ok(n1_ok),
    .out_side(n1_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n1_eye[i] = $signed(n1_side[i*IN_W +: IN_W]);
      n1_up[i]  = $signed(n1_side[3*IN_W + i*IN_W +: IN_W]);
      n2_f[i]   = $signed(n2_side[i*FW +: FW]);
      n2_eye[i] = $signed(n2_side[3*FW + i*IN_W +: IN_W]);
    end
  end

  assign n2_in[0]   = CW'(x_p[0]) - CW'(x_p[1]);
  assign n2_in[1]   = CW'(x_p[2]) - CW'(x_p[3]);
  assign n2_in[2]   = CW'(x_p[4]) - CW'(x_p[5]);
  assign n2_side_in = {x_okf, x_eye[2], x_eye[1], x_eye[0], x_f[2], x_f[1], x_f[0]};

  lavm_norm #(
    .IW(CW), .FRAC_BITS(FRAC_BITS), .SW(SW2)
  ) u_norm_s (
    .clk(clk), .rst(rst),
    .in_valid(x_valid), .in_ready(n2_ready), .in_vec(n2_in), .in_side(n2_side_in),
    .out_valid(n2_valid), .out_ready(p_ready), .out_vec(n2_s), .out_ok(n2_ok),
    .out_side(n2_side)
  );

  assign x_ready = !x_valid || n2_ready;
  assign p_ready = !p_valid || q_ready;
  assign q_ready = !q_valid || r_ready;
  assign r_ready = !r_valid || t_ready;
  assign t_ready = !t_valid || w_ready;
  assign w_ready = !w_valid || m_ready;
  assign m_ready = !m_valid || (out_ready && cnt == lavm_pkg::LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      r_valid <= 1'b0;
      t_valid <= 1'b0;
      w_valid <= 1'b0;
      m_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      if (x_ready) x_valid <= n1_valid;
      if (p_ready) p_valid <= n2_valid;
      if (q_ready) q_valid <= p_valid;
      if (r_ready) r_valid <= q_valid;
      if (t_ready) t_valid <= r_valid;
      if (w_ready) w_valid <= t_valid;
      if (m_ready) begin
        m_valid <= w_valid;
        cnt     <= '0;
      end else if (out_ready) begin
        cnt <= cnt + lavm_pkg::entry_index_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_ready) begin
      x_p[0] <= PW'(n1_f[1]) * PW'(n1_up[2]);
      x_p[1] <= PW'(n1_f[2]) * PW'(n1_up[1]);
      x_p[2] <= PW'(n1_f[2]) * PW'(n1_up[0]);
      x_p[3] <= PW'(n1_f[0]) * PW'(n1_up[2]);
      x_p[4] <= PW'(n1_f[0]) * PW'(n1_up[1]);
      x_p[5] <= PW'(n1_f[1]) * PW'(n1_up[0]);
      x_f    <= n1_f;
      x_eye  <= n1_eye;
      x_okf  <= n1_ok;
    end

    if (p_ready) begin
      p_uf[0] <= (2*FW)'(n2_s[1]) * (2*FW)'(n2_f[2]);
      p_uf[1] <= (2*FW)'(n2_s[2]) * (2*FW)'(n2_f[1]);
      p_uf[2] <= (2*FW)'(n2_s[2]) * (2*FW)'(n2_f[0]);
      p_uf[3] <= (2*FW)'(n2_s[0]) * (2*FW)'(n2_f[2]);
      p_uf[4] <= (2*FW)'(n2_s[0]) * (2*FW)'(n2_f[1]);
      p_uf[5] <= (2*FW)'(n2_s[1]) * (2*FW)'(n2_f[0]);
      for (int i = 0; i < 3; i++) begin
        p_se[i] <= PW'(n2_s[i]) * PW'(n2_eye[i]);
        p_fe[i] <= PW'(n2_f[i]) * PW'(n2_eye[i]);
      end
      p_s   <= n2_s;
      p_f   <= n2_f;
      p_eye <= n2_eye;
      p_deg <= !(n2_side[SW2-1] && n2_ok);
    end

    if (q_ready) begin
      q_ud[0] <= WW'(p_uf[0]) - WW'(p_uf[1]);
      q_ud[1] <= WW'(p_uf[2]) - WW'(p_uf[3]);
      q_ud[2] <= WW'(p_uf[4]) - WW'(p_uf[5]);
      q_ts    <= WW'(p_se[0]) + WW'(p_se[1]) + WW'(p_se[2]);
      q_tf    <= WW'(p_fe[0]) + WW'(p_fe[1]) + WW'(p_fe[2]);
      q_s     <= p_s;
      q_f     <= p_f;
      q_eye   <= p_eye;
      q_deg   <= p_deg;
    end

    if (r_ready) begin
      for (int i = 0; i < 3; i++) r_u[i] <= UW'(rescale(q_ud[i]));
      r_m12 <= -rescale(q_ts);
      r_m14 <= rescale(q_tf);
      r_s   <= q_s;
      r_f   <= q_f;
      r_eye <= q_eye;
      r_deg <= q_deg;
    end

    if (t_ready) begin
      for (int i = 0; i < 3; i++) t_ue[i] <= UEW'(r_u[i]) * UEW'(r_eye[i]);
      t_u   <= r_u;
      t_m12 <= r_m12;
      t_m14 <= r_m14;
      t_s   <= r_s;
      t_f   <= r_f;
      t_deg <= r_deg;
    end

    if (w_ready) begin
      w_tu  <= WW'(t_ue[0]) + WW'(t_ue[1]) + WW'(t_ue[2]);
      w_u   <= t_u;
      w_m12 <= t_m12;
      w_m14 <= t_m14;
      w_s   <= t_s;
      w_f   <= t_f;
      w_deg <= t_deg;
    end

    if (m_ready) begin
      for (int c = 0; c < 3; c++) begin
        mat[c*4 + 0] <= sat(WW'(w_s[c]));
        mat[c*4 + 1] <= sat(WW'(w_u[c]));
        mat[c*4 + 2] <= sat(-WW'(w_f[c]));
        mat[c*4 + 3] <= sat('0);
      end
      mat[12] <= sat(w_m12);
      mat[13] <= sat(-rescale(w_tu));
      mat[14] <= sat(w_m14);
      mat[15] <= sat(ONE);
      m_deg   <= w_deg;
    end
  end

  assign out_valid   = m_valid;
  assign entry_index = cnt;
  assign entry_value = mat[cnt];
  assign degenerate  = m_deg;
  assign last_entry  = (cnt == lavm_pkg::LAST_INDEX);

endmodule

`default_nettype wire

FILE: sv/lavm_checker.sv
// Port checker for the look-at view matrix block, bound to its top level.
// Depends on lavm_pkg and look_at_view_matrix_top_assert.svh.
`default_nettype none
`include "look_at_view_matrix_top_assert.svh"

module lavm_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire lavm_pkg::entry_index_t entry_index,
  input wire logic                   degenerate,
  input wire logic                   last_entry
);

  `LAVM_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid right after reset")
  `LAVM_ASSERT(a_last_marker, out_valid |-> (last_entry == (entry_index == lavm_pkg::LAST_INDEX)), "last marker off the final entry")
  `LAVM_ASSERT(a_index_step, (out_valid && out_ready && !last_entry) |=> (out_valid && entry_index == $past(entry_index) + lavm_pkg::entry_index_t'(1)), "matrix entries not consecutive")
  `LAVM_ASSERT(a_flag_steady, (out_valid && out_ready && !last_entry) |=> (degenerate == $past(degenerate)), "degenerate flag changed inside a matrix")

endmodule

bind look_at_view_matrix_top lavm_checker u_lavm_checker (.*);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for look_at_view_matrix_top: directed, random and
// backpressure items, each checked entry by entry against a local predictor.
// Depends on lavm_pkg and the block's RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    lavm_pkg::entry_index_t idx;
    logic [lavm_pkg::VALUE_WIDTH-1:0] value;
    logic degen;
    logic last;
  } view_entry_t;

  localparam longint SAT_HI = (64'sd1 <<< (lavm_pkg::VALUE_WIDTH - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_STALL_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [lavm_pkg::IN_WIDTH-1:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic signed [lavm_pkg::IN_WIDTH-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic signed [lavm_pkg::IN_WIDTH-1:0] upward_x = '0, upward_y = '0, upward_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lavm_pkg::entry_index_t entry_index;
  logic signed [lavm_pkg::VALUE_WIDTH-1:0] entry_value;
  logic degenerate;
  logic last_entry;

  view_entry_t pending_entries[$];
  int errors = 0;
  int items_sent = 0;
  int entries_seen = 0;
  int degenerate_items = 0;
  int cycles = 0;
  bit idle_on = 1'b0;
  int hold_off = 0;
  logic long_stall = 1'b0;
  event long_stall_go;

  look_at_view_matrix_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
    .out_valid(out_valid), .out_ready(out_ready), .entry_index(entry_index),
    .entry_value(entry_value), .degenerate(degenerate), .last_entry(last_entry)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint round_frac(input longint v);
    longint unsigned m;
    m = (magnitude(v) + (64'd1 << (lavm_pkg::FRAC_BITS - 1))) >> lavm_pkg::FRAC_BITS;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic bit unit_vector(input longint a, b, c,
                                     output longint x, y, z);
    longint unsigned ma, mb, mc, mx, len;
    ma = magnitude(a);
    mb = magnitude(b);
    mc = magnitude(c);
    mx = ma > mb ? ma : mb;
    mx = mc > mx ? mc : mx;
    x = 0; y = 0; z = 0;
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1; ma >>= 1; mb >>= 1; mc >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1; ma <<= 1; mb <<= 1; mc <<= 1;
    end
    len = floor_sqrt(ma * ma + mb * mb + mc * mc);
    x = longint'(((ma << lavm_pkg::FRAC_BITS) + (len >> 1)) / len);
    y = longint'(((mb << lavm_pkg::FRAC_BITS) + (len >> 1)) / len);
    z = longint'(((mc << lavm_pkg::FRAC_BITS) + (len >> 1)) / len);
    if (a < 0) x = -x;
    if (b < 0) y = -y;
    if (c < 0) z = -z;
    return 1'b1;
  endfunction

  function automatic logic [lavm_pkg::VALUE_WIDTH-1:0] clamp_entry(input longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[lavm_pkg::VALUE_WIDTH-1:0];
  endfunction

  function automatic void predict_view(input longint ex, ey, ez, tx, ty, tz,
                                       ux, uy, uz);
    longint fx, fy, fz, sx, sy, sz, vx, vy, vz;
    longint entries[16];
    bit ok_f, ok_s;
    view_entry_t e;
    ok_f = unit_vector(tx - ex, ty - ey, tz - ez, fx, fy, fz);
    ok_s = unit_vector(fy * uz - fz * uy, fz * ux - fx * uz, fx * uy - fy * ux,
                       sx, sy, sz);
    vx = round_frac(sy * fz - sz * fy);
    vy = round_frac(sz * fx - sx * fz);
    vz = round_frac(sx * fy - sy * fx);
    entries = '{sx, vx, -fx, 0, sy, vy, -fy, 0, sz, vz, -fz, 0,
                -round_frac(sx * ex + sy * ey + sz * ez),
                -round_frac(vx * ex + vy * ey + vz * ez),
                round_frac(fx * ex + fy * ey + fz * ez),
                64'sd1 <<< lavm_pkg::FRAC_BITS};
    if (!(ok_f && ok_s)) degenerate_items++;
    for (int k = 0; k < 16; k++) begin
      e.idx = lavm_pkg::entry_index_t'(k);
      e.value = clamp_entry(entries[k]);
      e.degen = !(ok_f && ok_s);
      e.last = (k == 15);
      pending_entries.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, exp);
    $display("Mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, exp);
    errors++;
  endtask

  always @(posedge clk) begin
    view_entry_t e;
    if (!rst && out_valid && out_ready) begin
      entries_seen++;
      if (pending_entries.size() == 0) begin
        report_mismatch("unexpected entry, entry_index", entry_index, -1);
      end else begin
        e = pending_entries.pop_front();
        if (entry_index !== e.idx) report_mismatch("entry_index", entry_index, e.idx);
        if (entry_value !== e.value)
          report_mismatch($sformatf("entry_value[%0d]", e.idx), entry_value,
                          longint'($signed(e.value)));
        if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
        if (last_entry !== e.last) report_mismatch("last_entry", last_entry, e.last);
      end
    end
  end

  always begin
    @(long_stall_go);
    for (int n = 0; n < LONG_STALL_CYCLES; n++) begin
      long_stall <= 1'b1;
      @(posedge clk);
    end
    long_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (long_stall) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      hold_off <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [lavm_pkg::IN_WIDTH-1:0] ex, ey, ez, tx, ty, tz,
                           ux, uy, uz);
    eye_x <= ex; eye_y <= ey; eye_z <= ez;
    target_x <= tx; target_y <= ty; target_z <= tz;
    upward_x <= ux; upward_y <= uy; upward_z <= uz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_view($signed(ex), $signed(ey), $signed(ez), $signed(tx), $signed(ty),
                 $signed(tz), $signed(ux), $signed(uy), $signed(uz));
    items_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [lavm_pkg::IN_WIDTH-1:0] scene_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return lavm_pkg::IN_WIDTH'($signed($urandom_range(0, 32'h01FF_FFFF))
                                    - 32'sh0100_0000);
      2: return lavm_pkg::IN_WIDTH'($signed($urandom_range(0, 32'h000F_FFFF))
                                    - 32'sh0008_0000);
      default: return lavm_pkg::IN_WIDTH'($signed($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  task automatic test_directed();
    logic [lavm_pkg::IN_WIDTH-1:0] mx, mn, one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    idle_on = 1'b1;
    send_item(0, 0, 5 * one, 0, 0, 0, 0, one, 0);
    send_item(one, 2 * one, 3 * one, 4 * one, -one, 0, 0, one, 0);
    send_item(one, one, one, one, one, one, 0, one, 0);
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(0, 0, 0, 0, one, 0, 0, one, 0);
    send_item(0, 0, 0, 0, 0, -one, 0, 0, 0);
    send_item(mx, mx, mx, mn, mn, mn, mx, mn, mx);
    send_item(mn, mn, mn, mx, mx, mx, mn, mx, mn);
    send_item(mn, 0, 0, mx, 0, 0, 0, mx, 0);
    send_item(mx, mx, mx, 0, 0, 0, 0, 0, mn);
    send_item(mn, mn, mn, 0, 0, 0, 0, 1, 0);
    send_item(mx, 0, mn, mn, mx, mx, 1, 0, 0);
    send_item(0, 0, 0, 1, 0, 0, 0, 0, 1);
    send_item(0, 0, 0, 0, 0, 1, mn, mn, mn);
    send_item(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0);
    send_item(3, -7, 11, -5, 2, 9, -1, 4, 6);
    send_item(mx, mx, mx, mx, mx, mn, 0, one, 0);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_random(input int count);
    logic [lavm_pkg::IN_WIDTH-1:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
    for (int i = 0; i < count; i++) begin
      ex = scene_coord(); ey = scene_coord(); ez = scene_coord();
      tx = scene_coord(); ty = scene_coord(); tz = scene_coord();
      ux = scene_coord(); uy = scene_coord(); uz = scene_coord();
      case ($urandom_range(0, 15))
        0: begin tx = ex; ty = ey; tz = ez; end
        1: begin ux = tx - ex; uy = ty - ey; uz = tz - ez; end
        2: begin ux = 0; uy = 0; uz = 0; end
        default: ;
      endcase
      send_item(ex, ey, ez, tx, ty, tz, ux, uy, uz);
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    -> long_stall_go;
    test_random(20);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(250);
    test_backpressure();
    test_random(60);
    idle_on = 1'b0;
    test_random(70);
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d items (%0d degenerate), checked %0d matrix entries,",
             items_sent, degenerate_items, entries_seen);
    $display("including random idling and a long output stall; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
